// ----- rtl/ssp_pkg.sv -----
// Shared types, sizes and constants for the shortest-path unit.
`default_nettype none

package ssp_pkg;

    localparam int MAX_VERTICES  = 32;
    localparam int WEIGHT_BITS   = 16;
    localparam int DIST_BITS     = 24;
    localparam int VTX_BITS      = $clog2(MAX_VERTICES);
    localparam int CNT_BITS      = $clog2(MAX_VERTICES + 1);
    localparam int MAT_DEPTH     = MAX_VERTICES * MAX_VERTICES;
    localparam int MAT_ADDR_BITS = $clog2(MAT_DEPTH);
    localparam int CFG_DATA_BITS = CNT_BITS;
    localparam int CFG_IDX_BITS  = 1;

    localparam logic [WEIGHT_BITS-1:0] NO_EDGE  = '1;
    localparam logic [DIST_BITS-1:0]   DIST_INF = '1;
    localparam logic [DIST_BITS-1:0]   DIST_MAX = DIST_INF - 1'b1;

    localparam logic [CFG_IDX_BITS-1:0] CFG_VERTEX_COUNT  = 1'b0;
    localparam logic [CFG_IDX_BITS-1:0] CFG_SOURCE_VERTEX = 1'b1;

    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_EDGE_RMW,
        ST_EDGE_MIRROR,
        ST_INIT,
        ST_SCAN,
        ST_PICK,
        ST_RELAX,
        ST_DRAIN,
        ST_EMIT
    } ssp_state_t;

endpackage

`default_nettype wire

// ----- rtl/ssp_ifs.sv -----
// Handshake interfaces for the edge input and the per-vertex result output.
`default_nettype none

interface ssp_edge_if;
    import ssp_pkg::*;

    logic                   valid;
    logic                   ready;
    logic [VTX_BITS-1:0]    from_vertex;
    logic [VTX_BITS-1:0]    dest_vertex;
    logic [WEIGHT_BITS-1:0] edge_weight;
    logic                   last_edge;

    modport source (output valid, from_vertex, dest_vertex, edge_weight, last_edge,
                    input ready);
    modport sink (input valid, from_vertex, dest_vertex, edge_weight, last_edge,
                  output ready);
endinterface

interface ssp_result_if;
    import ssp_pkg::*;

    logic                 valid;
    logic                 ready;
    logic [VTX_BITS-1:0]  vertex_id;
    logic [DIST_BITS-1:0] distance;
    logic [VTX_BITS-1:0]  predecessor;
    logic                 reachable;
    logic                 last_result;

    modport source (output valid, vertex_id, distance, predecessor, reachable,
                    last_result, input ready);
    modport sink (input valid, vertex_id, distance, predecessor, reachable,
                  last_result, output ready);
endinterface

`default_nettype wire

// ----- rtl/single_source_shortest_paths_unit.sv -----
// Single-source shortest-path unit: edge loader, Dijkstra sequencer, result emitter.
//
// Usage:
//   Edges arrive on the edges channel (valid/ready). Each edge inside the graph is
//   stored in both directions of a 32x32 weight matrix held in RAM, keeping the
//   smaller weight. Such an edge passes through accept, read-modify-write and
//   mirrored write; an edge outside the graph is accepted, then dropped unwritten.
//   The edge with last_edge set starts the search from source_vertex over the
//   vertex_count vertices (clamped to 1..32) in force at that edge (n below).
//   The search runs an init step and up to n rounds; a round is a minimum scan
//   over n vertices, a pick, a relax sweep over one matrix row and a drain, and
//   a closing scan and pick end it. It is bounded by the single matrix read port
//   and the single distance compare/add unit.
//   Results then leave on the results channel, one per vertex in ascending
//   order, through an output register: one per cycle while the receiver takes
//   them, held unchanged while it stalls. After the last result is loaded the
//   matrix is swept back to the no-edge mark, all 1024 entries, before the next
//   edge is taken. Reset starts the same sweep; configuration writes are taken
//   at any time, including during that sweep.
`default_nettype none

module single_source_shortest_paths_unit (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              cfg_we,
    input  wire logic [ssp_pkg::CFG_IDX_BITS-1:0]  cfg_index,
    input  wire logic [ssp_pkg::CFG_DATA_BITS-1:0] cfg_data,
    ssp_edge_if.sink                               edges,
    ssp_result_if.source                           results
);
    import ssp_pkg::*;

    ssp_state_t state_reg, state_next;

    logic [CNT_BITS-1:0]      vcount_reg;
    logic [VTX_BITS-1:0]      src_reg;
    logic [CNT_BITS-1:0]      n_reg, n_next;
    logic [VTX_BITS-1:0]      a_reg, a_next;
    logic [VTX_BITS-1:0]      b_reg, b_next;
    logic [WEIGHT_BITS-1:0]   w_reg, w_next;
    logic                     last_reg, last_next;
    logic [WEIGHT_BITS-1:0]   min_reg, min_next;
    logic [VTX_BITS-1:0]      idx_reg, idx_next;
    logic [VTX_BITS-1:0]      u_reg, u_next;
    logic [DIST_BITS-1:0]     du_reg, du_next;
    logic                     found_reg, found_next;
    logic                     proc_valid_reg, proc_valid_next;
    logic [VTX_BITS-1:0]      proc_idx_reg, proc_idx_next;
    logic [MAT_ADDR_BITS-1:0] clr_reg, clr_next;

    logic                   out_valid_reg, out_valid_next;
    logic [VTX_BITS-1:0]    out_vid_reg;
    logic [DIST_BITS-1:0]   out_dist_reg;
    logic [VTX_BITS-1:0]    out_pred_reg;
    logic                   out_reach_reg;
    logic                   out_last_reg;

    logic [DIST_BITS-1:0]   dist_reg [MAX_VERTICES];
    logic [VTX_BITS-1:0]    prev_reg [MAX_VERTICES];
    logic                   fin_reg  [MAX_VERTICES];

    logic                     ram_we;
    logic [MAT_ADDR_BITS-1:0] ram_waddr;
    logic [WEIGHT_BITS-1:0]   ram_wdata;
    logic [MAT_ADDR_BITS-1:0] ram_raddr;
    logic [WEIGHT_BITS-1:0]   ram_rdata;

    logic [CNT_BITS-1:0]    n_eff;
    logic [VTX_BITS-1:0]    last_idx;
    logic                   edge_ok;
    logic                   src_ok;
    logic [WEIGHT_BITS-1:0] edge_min;
    logic                   accept;
    logic                   out_load;
    logic                   init_en;
    logic                   pick_en;
    logic                   scan_cand;
    logic [DIST_BITS:0]     relax_sum;
    logic [DIST_BITS-1:0]   relax_dist;
    logic                   relax_upd;

    ssp_ram #(
        .WIDTH (WEIGHT_BITS),
        .DEPTH (MAT_DEPTH)
    ) u_matrix (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign n_eff = (vcount_reg == '0) ? CNT_BITS'(1) :
                   (vcount_reg > CNT_BITS'(MAX_VERTICES)) ? CNT_BITS'(MAX_VERTICES) :
                   vcount_reg;
    assign last_idx = VTX_BITS'(n_reg - 1'b1);
    assign edge_ok  = ({1'b0, a_reg} < n_reg) && ({1'b0, b_reg} < n_reg);
    assign src_ok   = {1'b0, src_reg} < n_reg;
    assign edge_min = (w_reg < ram_rdata) ? w_reg : ram_rdata;
    assign accept   = edges.valid && edges.ready;

    assign scan_cand = !fin_reg[idx_reg] && (!found_reg || dist_reg[idx_reg] < du_reg);

    assign relax_sum  = {1'b0, du_reg} + (DIST_BITS + 1)'(ram_rdata);
    assign relax_dist = (relax_sum > {1'b0, DIST_MAX}) ? DIST_MAX : relax_sum[DIST_BITS-1:0];
    assign relax_upd  = proc_valid_reg && !fin_reg[proc_idx_reg] && (ram_rdata != NO_EDGE)
                        && (relax_dist < dist_reg[proc_idx_reg]);

    assign edges.ready = (state_reg == ST_IDLE);

    assign results.valid       = out_valid_reg;
    assign results.vertex_id   = out_vid_reg;
    assign results.distance    = out_dist_reg;
    assign results.predecessor = out_pred_reg;
    assign results.reachable   = out_reach_reg;
    assign results.last_result = out_last_reg;

    always_comb
    begin
        state_next      = state_reg;
        n_next          = n_reg;
        a_next          = a_reg;
        b_next          = b_reg;
        w_next          = w_reg;
        last_next       = last_reg;
        min_next        = min_reg;
        idx_next        = idx_reg;
        u_next          = u_reg;
        du_next         = du_reg;
        found_next      = found_reg;
        proc_valid_next = 1'b0;
        proc_idx_next   = proc_idx_reg;
        clr_next        = clr_reg;
        out_load        = 1'b0;
        init_en         = 1'b0;
        pick_en         = 1'b0;
        ram_we          = 1'b0;
        ram_waddr       = {a_reg, b_reg};
        ram_wdata       = min_reg;
        ram_raddr       = {u_reg, idx_reg};

        unique case (state_reg)
            ST_CLEAR:
            begin
                ram_we    = 1'b1;
                ram_waddr = clr_reg;
                ram_wdata = NO_EDGE;
                clr_next  = clr_reg + 1'b1;
                if (clr_reg == MAT_ADDR_BITS'(MAT_DEPTH - 1))
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                ram_raddr = {edges.from_vertex, edges.dest_vertex};
                if (accept)
                begin
                    a_next     = edges.from_vertex;
                    b_next     = edges.dest_vertex;
                    w_next     = edges.edge_weight;
                    last_next  = edges.last_edge;
                    n_next     = n_eff;
                    state_next = ST_EDGE_RMW;
                end
            end
            ST_EDGE_RMW:
            begin
                min_next = edge_min;
                if (edge_ok)
                begin
                    ram_we     = 1'b1;
                    ram_waddr  = {a_reg, b_reg};
                    ram_wdata  = edge_min;
                    state_next = ST_EDGE_MIRROR;
                end
                else
                begin
                    state_next = last_reg ? ST_INIT : ST_IDLE;
                end
            end
            ST_EDGE_MIRROR:
            begin
                ram_we     = 1'b1;
                ram_waddr  = {b_reg, a_reg};
                ram_wdata  = min_reg;
                state_next = last_reg ? ST_INIT : ST_IDLE;
            end
            ST_INIT:
            begin
                init_en    = 1'b1;
                idx_next   = '0;
                found_next = 1'b0;
                du_next    = DIST_INF;
                state_next = ST_SCAN;
            end
            ST_SCAN:
            begin
                if (scan_cand)
                begin
                    u_next     = idx_reg;
                    du_next    = dist_reg[idx_reg];
                    found_next = 1'b1;
                end
                if (idx_reg == last_idx)
                begin
                    state_next = ST_PICK;
                end
                else
                begin
                    idx_next = idx_reg + 1'b1;
                end
            end
            ST_PICK:
            begin
                idx_next = '0;
                if (!found_reg || du_reg == DIST_INF)
                begin
                    state_next = ST_EMIT;
                end
                else
                begin
                    pick_en    = 1'b1;
                    state_next = ST_RELAX;
                end
            end
            ST_RELAX:
            begin
                ram_raddr       = {u_reg, idx_reg};
                proc_valid_next = 1'b1;
                proc_idx_next   = idx_reg;
                if (idx_reg == last_idx)
                begin
                    state_next = ST_DRAIN;
                end
                else
                begin
                    idx_next = idx_reg + 1'b1;
                end
            end
            ST_DRAIN:
            begin
                idx_next   = '0;
                found_next = 1'b0;
                du_next    = DIST_INF;
                state_next = ST_SCAN;
            end
            ST_EMIT:
            begin
                if (!out_valid_reg || results.ready)
                begin
                    out_load = 1'b1;
                    if (idx_reg == last_idx)
                    begin
                        clr_next   = '0;
                        state_next = ST_CLEAR;
                    end
                    else
                    begin
                        idx_next = idx_reg + 1'b1;
                    end
                end
            end
            default:
            begin
                state_next = ST_CLEAR;
                clr_next   = '0;
            end
        endcase

        if (out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (results.ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_CLEAR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vcount_reg     <= CNT_BITS'(MAX_VERTICES);
            src_reg        <= '0;
            clr_reg        <= '0;
            proc_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
            found_reg      <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                unique case (cfg_index)
                    CFG_VERTEX_COUNT:  vcount_reg <= cfg_data;
                    CFG_SOURCE_VERTEX: src_reg    <= cfg_data[VTX_BITS-1:0];
                    default:           ;
                endcase
            end
            clr_reg        <= clr_next;
            proc_valid_reg <= proc_valid_next;
            out_valid_reg  <= out_valid_next;
            found_reg      <= found_next;
        end
    end

    always_ff @(posedge clk)
    begin
        n_reg        <= n_next;
        a_reg        <= a_next;
        b_reg        <= b_next;
        w_reg        <= w_next;
        last_reg     <= last_next;
        min_reg      <= min_next;
        idx_reg      <= idx_next;
        u_reg        <= u_next;
        du_reg       <= du_next;
        proc_idx_reg <= proc_idx_next;

        if (out_load)
        begin
            out_vid_reg   <= idx_reg;
            out_dist_reg  <= dist_reg[idx_reg];
            out_pred_reg  <= prev_reg[idx_reg];
            out_reach_reg <= (dist_reg[idx_reg] != DIST_INF);
            out_last_reg  <= (idx_reg == last_idx);
        end

        if (init_en)
        begin
            for (int i = 0; i < MAX_VERTICES; i++)
            begin
                dist_reg[i] <= (src_ok && (VTX_BITS'(i) == src_reg)) ? '0 : DIST_INF;
                prev_reg[i] <= VTX_BITS'(i);
                fin_reg[i]  <= 1'b0;
            end
        end

        if (pick_en)
        begin
            fin_reg[u_reg] <= 1'b1;
        end

        if (relax_upd)
        begin
            dist_reg[proc_idx_reg] <= relax_dist;
            prev_reg[proc_idx_reg] <= u_reg;
        end
    end

    a_last_matches_count: assert property (@(posedge clk) disable iff (!rst_n)
        results.valid && results.last_result |-> results.vertex_id == last_idx)
        else $error("last result does not describe the final vertex");

    a_unreachable_fields: assert property (@(posedge clk) disable iff (!rst_n)
        results.valid && !results.reachable |->
        results.predecessor == results.vertex_id && results.distance == DIST_INF)
        else $error("unreachable vertex with a path");

    a_pick_marks_finished: assert property (@(posedge clk) disable iff (!rst_n)
        pick_en |=> fin_reg[u_reg])
        else $error("picked vertex not marked finished");

    a_accept_starts_rmw: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> state_reg == ST_EDGE_RMW)
        else $error("accepted edge not stored");

    a_relax_follows_issue: assert property (@(posedge clk) disable iff (!rst_n)
        proc_valid_reg |-> $past(state_reg) == ST_RELAX)
        else $error("relax data without a matrix read");

endmodule

`default_nettype wire

// ----- rtl/ssp_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
`default_nettype none

module ssp_ram #(
    parameter int WIDTH     = 16,
    parameter int DEPTH     = 1024,
    parameter int ADDR_BITS = $clog2(DEPTH)
) (
    input  wire logic                 clk,
    input  wire logic                 we,
    input  wire logic [ADDR_BITS-1:0] waddr,
    input  wire logic [WIDTH-1:0]     wdata,
    input  wire logic [ADDR_BITS-1:0] raddr,
    output logic      [WIDTH-1:0]     rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire
